[sv/qclass_pkg.sv]
// qclass_pkg: shared widths, point types and shape codes for the quadrilateral classifier
// used by qclass_sort, qclass_edge and quadrilateral_classifier; no dependencies
package qclass_pkg;

   localparam int COORD_BITS = 16;
   localparam int OFF_BITS   = COORD_BITS + 1;
   localparam int PROD_BITS  = 2 * OFF_BITS;
   localparam int SUM_BITS   = PROD_BITS + 1;
   localparam int SHAPE_BITS = 2;

   typedef logic signed [COORD_BITS-1:0] coord_type;
   typedef logic signed [OFF_BITS-1:0]   off_type;
   typedef logic signed [PROD_BITS-1:0]  prod_type;
   typedef logic signed [SUM_BITS-1:0]   sum_type;
   typedef logic [SHAPE_BITS-1:0]        shape_type;

   typedef struct packed {
      coord_type x;
      coord_type y;
   } point_type;

   typedef point_type [3:0] quad_type;

   localparam shape_type SHAPE_SQUARE    = 2'd0;
   localparam shape_type SHAPE_RHOMBUS   = 2'd1;
   localparam shape_type SHAPE_RECTANGLE = 2'd2;
   localparam shape_type SHAPE_OTHER     = 2'd3;

endpackage

[sv/qclass_sort.sv]
// qclass_sort: one compare-and-swap step of the angular sort around the fourth point
// two register stages: cross product terms, then sign test and swap; uses qclass_pkg
module qclass_sort (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 pair_hi,
   input  logic                 in_valid,
   output logic                 in_stall,
   input  qclass_pkg::quad_type in_pts,
   output logic                 out_valid,
   input  logic                 out_stall,
   output qclass_pkg::quad_type out_pts
);

   logic                  a_valid_ff;
   qclass_pkg::quad_type  a_pts_ff;
   qclass_pkg::prod_type  a_prod_l_ff;
   qclass_pkg::prod_type  a_prod_r_ff;
   qclass_pkg::prod_type  a_prod_l_in;
   qclass_pkg::prod_type  a_prod_r_in;

   logic                  b_valid_ff;
   qclass_pkg::quad_type  b_pts_ff;
   qclass_pkg::quad_type  b_pts_in;

   logic                  adv_a;
   logic                  adv_b;

   qclass_pkg::point_type pt_lo;
   qclass_pkg::point_type pt_up;
   qclass_pkg::off_type   ax;
   qclass_pkg::off_type   ay;
   qclass_pkg::off_type   bx;
   qclass_pkg::off_type   by;
   qclass_pkg::sum_type   cross_w;

   assign adv_b    = !b_valid_ff || !out_stall;
   assign adv_a    = !a_valid_ff || adv_b;
   assign in_stall = !adv_a;

   // offsets from the origin point and the two cross product terms
   always_comb begin
      pt_lo = pair_hi ? in_pts[1] : in_pts[0];
      pt_up = pair_hi ? in_pts[2] : in_pts[1];
      ax = qclass_pkg::off_type'(pt_lo.x) - qclass_pkg::off_type'(in_pts[3].x);
      ay = qclass_pkg::off_type'(pt_lo.y) - qclass_pkg::off_type'(in_pts[3].y);
      bx = qclass_pkg::off_type'(pt_up.x) - qclass_pkg::off_type'(in_pts[3].x);
      by = qclass_pkg::off_type'(pt_up.y) - qclass_pkg::off_type'(in_pts[3].y);
      a_prod_l_in = qclass_pkg::prod_type'(ax) * qclass_pkg::prod_type'(by);
      a_prod_r_in = qclass_pkg::prod_type'(ay) * qclass_pkg::prod_type'(bx);
   end

   // swap the pair on a negative cross product
   always_comb begin
      cross_w = qclass_pkg::sum_type'(a_prod_l_ff) - qclass_pkg::sum_type'(a_prod_r_ff);
      b_pts_in = a_pts_ff;
      if (cross_w[qclass_pkg::SUM_BITS-1]) begin
         if (pair_hi) begin
            b_pts_in[1] = a_pts_ff[2];
            b_pts_in[2] = a_pts_ff[1];
         end else begin
            b_pts_in[0] = a_pts_ff[1];
            b_pts_in[1] = a_pts_ff[0];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         a_valid_ff <= 1'b0;
         b_valid_ff <= 1'b0;
      end else begin
         if (adv_a) begin
            a_valid_ff <= in_valid;
         end
         if (adv_b) begin
            b_valid_ff <= a_valid_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (adv_a) begin
         a_pts_ff    <= in_pts;
         a_prod_l_ff <= a_prod_l_in;
         a_prod_r_ff <= a_prod_r_in;
      end
      if (adv_b) begin
         b_pts_ff <= b_pts_in;
      end
   end

   assign out_valid = b_valid_ff;
   assign out_pts   = b_pts_ff;

endmodule

[sv/qclass_edge.sv]
// qclass_edge: edge vectors, squared lengths and dot products of the closed path,
// then the shape decision into the output register; uses qclass_pkg
module qclass_edge (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  in_valid,
   output logic                  in_stall,
   input  qclass_pkg::quad_type  in_pts,
   output logic                  out_valid,
   input  logic                  out_stall,
   output qclass_pkg::shape_type out_shape
);

   logic                  d_valid_ff;
   qclass_pkg::prod_type  sq_x_ff [4];
   qclass_pkg::prod_type  sq_y_ff [4];
   qclass_pkg::prod_type  dp_x_ff [3];
   qclass_pkg::prod_type  dp_y_ff [3];
   qclass_pkg::prod_type  sq_x_in [4];
   qclass_pkg::prod_type  sq_y_in [4];
   qclass_pkg::prod_type  dp_x_in [3];
   qclass_pkg::prod_type  dp_y_in [3];
   qclass_pkg::off_type   ex [4];
   qclass_pkg::off_type   ey [4];

   logic                  o_valid_ff;
   qclass_pkg::shape_type o_shape_ff;
   qclass_pkg::shape_type o_shape_in;

   qclass_pkg::sum_type   len_w [4];
   qclass_pkg::sum_type   dot_w [3];
   logic                  sides_equal;
   logic                  right_angles;

   logic                  adv_d;
   logic                  adv_e;

   assign adv_e    = !o_valid_ff || !out_stall;
   assign adv_d    = !d_valid_ff || adv_e;
   assign in_stall = !adv_d;

   // edge i runs from point i to point i+1, wrapping back to point 0
   always_comb begin
      for (int i = 0; i < 4; i++) begin
         ex[i] = qclass_pkg::off_type'(in_pts[(i + 1) % 4].x) - qclass_pkg::off_type'(in_pts[i].x);
         ey[i] = qclass_pkg::off_type'(in_pts[(i + 1) % 4].y) - qclass_pkg::off_type'(in_pts[i].y);
         sq_x_in[i] = qclass_pkg::prod_type'(ex[i]) * qclass_pkg::prod_type'(ex[i]);
         sq_y_in[i] = qclass_pkg::prod_type'(ey[i]) * qclass_pkg::prod_type'(ey[i]);
      end
      for (int i = 0; i < 3; i++) begin
         dp_x_in[i] = qclass_pkg::prod_type'(ex[i]) * qclass_pkg::prod_type'(ex[i + 1]);
         dp_y_in[i] = qclass_pkg::prod_type'(ey[i]) * qclass_pkg::prod_type'(ey[i + 1]);
      end
   end

   always_comb begin
      for (int i = 0; i < 4; i++) begin
         len_w[i] = qclass_pkg::sum_type'(sq_x_ff[i]) + qclass_pkg::sum_type'(sq_y_ff[i]);
      end
      for (int i = 0; i < 3; i++) begin
         dot_w[i] = qclass_pkg::sum_type'(dp_x_ff[i]) + qclass_pkg::sum_type'(dp_y_ff[i]);
      end
      sides_equal  = (len_w[0] == len_w[1]) && (len_w[1] == len_w[2]) &&
                     (len_w[2] == len_w[3]);
      right_angles = (dot_w[0] == '0) && (dot_w[1] == '0) && (dot_w[2] == '0);
      case ({sides_equal, right_angles})
         2'b11:   o_shape_in = qclass_pkg::SHAPE_SQUARE;
         2'b10:   o_shape_in = qclass_pkg::SHAPE_RHOMBUS;
         2'b01:   o_shape_in = qclass_pkg::SHAPE_RECTANGLE;
         default: o_shape_in = qclass_pkg::SHAPE_OTHER;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         d_valid_ff <= 1'b0;
         o_valid_ff <= 1'b0;
      end else begin
         if (adv_d) begin
            d_valid_ff <= in_valid;
         end
         if (adv_e) begin
            o_valid_ff <= d_valid_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (adv_d) begin
         sq_x_ff <= sq_x_in;
         sq_y_ff <= sq_y_in;
         dp_x_ff <= dp_x_in;
         dp_y_ff <= dp_y_in;
      end
      if (adv_e) begin
         o_shape_ff <= o_shape_in;
      end
   end

   assign out_valid = o_valid_ff;
   assign out_shape = o_shape_ff;

endmodule

[sv/quadrilateral_classifier.sv]
// quadrilateral_classifier: an accepted item passes through these register stages to its result
// (three sort steps of two stages each, then the product and decision stages)
// throughput one item per cycle while rsp_stall is low; every stage holds a valid bit and a stage with
// no valid item takes a new one even while the output is stalled
// synchronous active-high reset clears all valid bits; data registers are not reset
// depends on qclass_pkg, qclass_sort and qclass_edge
module quadrilateral_classifier (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_stall,
   input  qclass_pkg::coord_type req_p0_x,
   input  qclass_pkg::coord_type req_p0_y,
   input  qclass_pkg::coord_type req_p1_x,
   input  qclass_pkg::coord_type req_p1_y,
   input  qclass_pkg::coord_type req_p2_x,
   input  qclass_pkg::coord_type req_p2_y,
   input  qclass_pkg::coord_type req_p3_x,
   input  qclass_pkg::coord_type req_p3_y,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output qclass_pkg::shape_type rsp_shape_class
);

   qclass_pkg::quad_type req_pts;
   qclass_pkg::quad_type s0_pts;
   qclass_pkg::quad_type s1_pts;
   qclass_pkg::quad_type s2_pts;
   logic                 s0_valid;
   logic                 s1_valid;
   logic                 s2_valid;
   logic                 s0_stall;
   logic                 s1_stall;
   logic                 s2_stall;

   assign req_pts[0].x = req_p0_x;
   assign req_pts[0].y = req_p0_y;
   assign req_pts[1].x = req_p1_x;
   assign req_pts[1].y = req_p1_y;
   assign req_pts[2].x = req_p2_x;
   assign req_pts[2].y = req_p2_y;
   assign req_pts[3].x = req_p3_x;
   assign req_pts[3].y = req_p3_y;

   // sort steps on pairs (0,1), (1,2), (0,1)
   qclass_sort u_sort0 (
      .clock     (clock),
      .reset     (reset),
      .pair_hi   (1'b0),
      .in_valid  (req_valid),
      .in_stall  (req_stall),
      .in_pts    (req_pts),
      .out_valid (s0_valid),
      .out_stall (s0_stall),
      .out_pts   (s0_pts)
   );

   qclass_sort u_sort1 (
      .clock     (clock),
      .reset     (reset),
      .pair_hi   (1'b1),
      .in_valid  (s0_valid),
      .in_stall  (s0_stall),
      .in_pts    (s0_pts),
      .out_valid (s1_valid),
      .out_stall (s1_stall),
      .out_pts   (s1_pts)
   );

   qclass_sort u_sort2 (
      .clock     (clock),
      .reset     (reset),
      .pair_hi   (1'b0),
      .in_valid  (s1_valid),
      .in_stall  (s1_stall),
      .in_pts    (s1_pts),
      .out_valid (s2_valid),
      .out_stall (s2_stall),
      .out_pts   (s2_pts)
   );

   qclass_edge u_edge (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (s2_valid),
      .in_stall  (s2_stall),
      .in_pts    (s2_pts),
      .out_valid (rsp_valid),
      .out_stall (rsp_stall),
      .out_shape (rsp_shape_class)
   );

   // input side only stalls when the whole pipeline is full behind a stalled result
   assert property (@(posedge clock) disable iff (reset)
      req_stall |-> (rsp_valid && rsp_stall))
      else $error("input stalled while the output is free");

   // no result right after reset
   assert property (@(posedge clock) disable iff (reset)
      $past(reset) |-> !rsp_valid)
      else $error("result valid right after reset");

   // no input stall while no result is waiting
   assert property (@(posedge clock) disable iff (reset)
      !rsp_valid |-> !req_stall)
      else $error("input stalled with an empty output register");

endmodule

[tb/sv/quadrilateral_classifier_tb.sv]
`timescale 1ns / 1ps
// quadrilateral_classifier_tb: self-checking bench that sends point sets and checks each shape code
// holds its own classifier, directed and random shapes, random stalls on both sides
// depends on qclass_pkg and quadrilateral_classifier
module quadrilateral_classifier_tb;
   import qclass_pkg::*;

   localparam int LATENCY     = 8;
   localparam int HOLD_CYCLES = 60;
   localparam int QUIET_LIMIT = 5000;
   localparam int DRAIN_LIMIT = 5000;

   class shape_checker;
      shape_type expected_shapes[$];
      int        errors;
      int        items;
      int        seen[4];

      function shape_type classify_quad(quad_type q);
         longint px[4];
         longint py[4];
         longint t;
         longint cross_v;
         longint ux, uy, vx, vy;
         int     order_steps[3];
         int     k, a, b, c;
         bit     sides_equal;
         bit     right_angles;
         order_steps = '{0, 1, 0};
         for (int i = 0; i < 4; i++) begin
            px[i] = longint'(q[i].x);
            py[i] = longint'(q[i].y);
         end
         // bubble pass on the angle around the fourth point
         for (int s = 0; s < 3; s++) begin
            k = order_steps[s];
            cross_v = (px[k] - px[3]) * (py[k+1] - py[3]) - (py[k] - py[3]) * (px[k+1] - px[3]);
            if (cross_v < 0) begin
               t = px[k]; px[k] = px[k+1]; px[k+1] = t;
               t = py[k]; py[k] = py[k+1]; py[k+1] = t;
            end
         end
         sides_equal  = 1'b1;
         right_angles = 1'b1;
         for (int i = 0; i < 3; i++) begin
            a  = i;
            b  = (i + 1) & 3;
            c  = (i + 2) & 3;
            ux = px[b] - px[a];
            uy = py[b] - py[a];
            vx = px[c] - px[b];
            vy = py[c] - py[b];
            if (ux * ux + uy * uy != vx * vx + vy * vy) sides_equal = 1'b0;
            if (ux * vx + uy * vy != 0) right_angles = 1'b0;
         end
         if (sides_equal) return right_angles ? SHAPE_SQUARE : SHAPE_RHOMBUS;
         return right_angles ? SHAPE_RECTANGLE : SHAPE_OTHER;
      endfunction

      task report_error(string msg);
         $display("[%0t] mismatch: %s", $time, msg);
         errors++;
      endtask

      function void note_points(quad_type q);
         expected_shapes.push_back(classify_quad(q));
         items++;
      endfunction

      task check_shape(shape_type got);
         shape_type want;
         if (expected_shapes.size() == 0) begin
            report_error($sformatf("shape_class %0d with no item outstanding", got));
         end else begin
            want = expected_shapes.pop_front();
            seen[got]++;
            if (got !== want)
               report_error($sformatf("shape_class got %0d, expected %0d", got, want));
         end
      endtask

      function int pending();
         return expected_shapes.size();
      endfunction
   endclass

   logic      clock;
   logic      reset;
   logic      req_valid;
   logic      req_stall;
   coord_type req_p0_x, req_p0_y, req_p1_x, req_p1_y;
   coord_type req_p2_x, req_p2_y, req_p3_x, req_p3_y;
   logic      rsp_valid;
   logic      rsp_stall;
   shape_type rsp_shape_class;

   shape_checker board;
   bit           tx_quiet;
   bit           rx_quiet;
   bit           hold_off_req;
   int           quiet_cycles;
   int           input_stall_cycles;

   quadrilateral_classifier DUT (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_p0_x        (req_p0_x),
      .req_p0_y        (req_p0_y),
      .req_p1_x        (req_p1_x),
      .req_p1_y        (req_p1_y),
      .req_p2_x        (req_p2_x),
      .req_p2_y        (req_p2_y),
      .req_p3_x        (req_p3_x),
      .req_p3_y        (req_p3_y),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_shape_class (rsp_shape_class)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   function automatic quad_type make_quad(int x0, int y0, int x1, int y1,
                                          int x2, int y2, int x3, int y3);
      quad_type q;
      q[0].x = coord_type'(x0); q[0].y = coord_type'(y0);
      q[1].x = coord_type'(x1); q[1].y = coord_type'(y1);
      q[2].x = coord_type'(x2); q[2].y = coord_type'(y2);
      q[3].x = coord_type'(x3); q[3].y = coord_type'(y3);
      return q;
   endfunction

   // mostly well-formed squares, rhombi and rectangles, the rest noise and tiny grids
   function automatic quad_type random_quad();
      quad_type q;
      int kind, ox, oy, ax, ay, bx, by, c, j, tmp;
      int vx[3];
      int vy[3];
      int slot[3];
      kind = $urandom_range(99);
      if (kind < 30) begin
         for (int i = 0; i < 4; i++) begin
            q[i].x = coord_type'($urandom);
            q[i].y = coord_type'($urandom);
         end
         return q;
      end
      if (kind < 45) begin
         for (int i = 0; i < 4; i++) begin
            q[i].x = coord_type'(int'($urandom_range(6)) - 3);
            q[i].y = coord_type'(int'($urandom_range(6)) - 3);
         end
         return q;
      end
      ox = int'($urandom_range(32767)) - 16384;
      oy = int'($urandom_range(32767)) - 16384;
      ax = int'($urandom_range(8000)) - 4000;
      ay = int'($urandom_range(8000)) - 4000;
      if (kind < 65) begin
         bx = -ay;
         by = ax;
      end else if (kind < 80) begin
         case ($urandom_range(2))
            0: begin bx = ay;  by = ax;  end
            1: begin bx = ax;  by = -ay; end
            default: begin bx = -ax; by = ay; end
         endcase
      end else begin
         c  = $urandom_range(3, 1);
         bx = -ay * c;
         by = ax * c;
      end
      vx   = '{ax, ax + bx, bx};
      vy   = '{ay, ay + by, by};
      slot = '{0, 1, 2};
      for (int i = 2; i > 0; i--) begin
         j = $urandom_range(i);
         tmp = slot[i]; slot[i] = slot[j]; slot[j] = tmp;
      end
      for (int i = 0; i < 3; i++) begin
         q[slot[i]].x = coord_type'(ox + vx[i]);
         q[slot[i]].y = coord_type'(oy + vy[i]);
      end
      q[3].x = coord_type'(ox);
      q[3].y = coord_type'(oy);
      return q;
   endfunction

   // called at a falling edge, returns at the falling edge after acceptance
   task automatic send_item(quad_type q);
      req_valid = 1'b1;
      req_p0_x = q[0].x; req_p0_y = q[0].y;
      req_p1_x = q[1].x; req_p1_y = q[1].y;
      req_p2_x = q[2].x; req_p2_y = q[2].y;
      req_p3_x = q[3].x; req_p3_y = q[3].y;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      board.note_points(q);
      @(negedge clock);
   endtask

   task automatic offer_points(quad_type q);
      if (!tx_quiet) begin
         while ($urandom_range(99) < 29) begin
            req_valid = 1'b0;
            @(negedge clock);
         end
      end
      send_item(q);
   endtask

   task automatic drain_results();
      int waited;
      waited = 0;
      req_valid = 1'b0;
      while (board.pending() != 0 && waited < DRAIN_LIMIT) begin
         @(negedge clock);
         waited++;
      end
   endtask

   // receiver: random stalls, quiet stretches and one long hold-off
   initial begin
      rsp_stall = 1'b0;
      forever begin
         @(negedge clock);
         if (hold_off_req) begin
            rsp_stall = 1'b1;
            repeat (HOLD_CYCLES) @(negedge clock);
            rsp_stall    = 1'b0;
            hold_off_req = 1'b0;
         end else begin
            rsp_stall = rx_quiet ? 1'b0 : ($urandom_range(99) < 29);
         end
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) board.check_shape(rsp_shape_class);
   end

   initial begin
      quiet_cycles       = 0;
      input_stall_cycles = 0;
      while (quiet_cycles < QUIET_LIMIT) begin
         @(posedge clock);
         if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall)) quiet_cycles = 0;
         else quiet_cycles++;
         if (req_valid && req_stall) input_stall_cycles++;
      end
      $display("timeout after %0d cycles with no item moving", QUIET_LIMIT);
      $display("quadrilateral_classifier_tb: FAIL");
      $finish;
   end

   initial begin
      board        = new();
      tx_quiet     = 1'b0;
      rx_quiet     = 1'b0;
      hold_off_req = 1'b0;
      reset        = 1'b1;
      req_valid    = 1'b0;
      req_p0_x = '0; req_p0_y = '0; req_p1_x = '0; req_p1_y = '0;
      req_p2_x = '0; req_p2_y = '0; req_p3_x = '0; req_p3_y = '0;
      repeat (8) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // directed: degenerate, extremes, tied angles, each shape class
      offer_points(make_quad(0, 0, 0, 0, 0, 0, 0, 0));
      offer_points(make_quad(32767, 32767, 32767, 32767, 32767, 32767, 32767, 32767));
      offer_points(make_quad(-32768, -32768, -32768, -32768, -32768, -32768, -32768, -32768));
      offer_points(make_quad(-1, -1, -1, -1, -1, -1, -1, -1));
      offer_points(make_quad(1, 0, 1, 1, 0, 1, 0, 0));
      offer_points(make_quad(0, 1, 1, 1, 1, 0, 0, 0));
      offer_points(make_quad(32767, -32768, 32767, 32767, -32768, 32767, -32768, -32768));
      offer_points(make_quad(-32768, 32767, 32767, 32767, 32767, -32768, -32768, -32768));
      offer_points(make_quad(2, 1, 3, 3, 1, 2, 0, 0));
      offer_points(make_quad(1, 2, 2, 1, 3, 3, 0, 0));
      offer_points(make_quad(4, 0, 4, 2, 0, 2, 0, 0));
      offer_points(make_quad(32767, 0, 32767, 5, -32768, 5, -32768, 0));
      offer_points(make_quad(1, 1, 2, 2, 3, 3, 0, 0));
      offer_points(make_quad(1, 0, -1, 0, 0, 1, 0, 0));
      offer_points(make_quad(5, 5, 5, 5, 0, 5, 0, 0));
      offer_points(make_quad(32767, -32768, -32768, 32767, 0, 0, -1, -1));
      offer_points(make_quad(3, 0, 4, 2, 1, 2, 0, 0));
      offer_points(make_quad(3, 4, -1, 7, -4, 3, 0, 0));
      offer_points(make_quad(-4, 3, 3, 4, -1, 7, 0, 0));
      offer_points(make_quad(32767, 32767, -32768, -32768, 32767, -32768, 0, 0));
      drain_results();

      repeat (450) offer_points(random_quad());

      tx_quiet = 1'b1;
      rx_quiet = 1'b1;
      repeat (200) offer_points(random_quad());
      rx_quiet = 1'b0;

      // receiver holds off while items keep coming, so the pipe fills up
      hold_off_req = 1'b1;
      repeat (40) offer_points(random_quad());
      tx_quiet = 1'b0;
      drain_results();

      repeat (400) offer_points(random_quad());
      drain_results();
      repeat (2 * LATENCY + 4) @(negedge clock);

      if (board.pending() != 0)
         board.report_error($sformatf("%0d shapes never came out", board.pending()));
      $display("checked %0d point sets: %0d square, %0d rhombus, %0d rectangle, %0d other",
               board.items, board.seen[SHAPE_SQUARE], board.seen[SHAPE_RHOMBUS],
               board.seen[SHAPE_RECTANGLE], board.seen[SHAPE_OTHER]);
      $display("input held back for %0d cycles, %0d mismatches",
               input_stall_cycles, board.errors);
      if (board.errors == 0) begin
         $display("quadrilateral_classifier_tb: PASS");
      end else begin
         $display("quadrilateral_classifier_tb: FAIL");
      end
      $finish;
   end

endmodule

[quadrilateral_classifier.f]
sv/qclass_pkg.sv
sv/qclass_sort.sv
sv/qclass_edge.sv
sv/quadrilateral_classifier.sv
tb/sv/quadrilateral_classifier_tb.sv
